>>> rtl/mfb_pkg.sv
package mfb_pkg;

  // Command codes
  localparam logic [2:0] CMD_PIXEL   = 3'd0;
  localparam logic [2:0] CMD_FILL    = 3'd1;
  localparam logic [2:0] CMD_BM_START = 3'd2;
  localparam logic [2:0] CMD_BM_BYTE = 3'd3;
  localparam logic [2:0] CMD_REFRESH = 3'd4;

  // Refresh stream command bytes
  localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD    = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD   = 8'h10;

  // One unit of back-end work: a refresh step or a clipped draw region
  typedef struct packed {
    logic       is_refresh;
    logic [7:0] x_first;
    logic [7:0] x_last;
    logic [7:0] y_first;
    logic [7:0] y_last;
    logic [7:0] pattern;   // bit k: value of column x_first + k
  } op_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

>>> rtl/mfb_queue.sv
module mfb_queue import mfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  head_op_o,
  output logic empty_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign head_op_o = slot_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_op_i;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/mfb_front.sv
module mfb_front import mfb_pkg::*; #(
  parameter int PIXEL_WIDTH  = 128,
  parameter int PIXEL_HEIGHT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [2:0]   command_i,
  input  logic [7:0]   x_i,
  input  logic [7:0]   y_i,
  input  logic [7:0]   width_i,
  input  logic [7:0]   height_i,
  input  logic         colour_i,
  input  logic [7:0]   image_byte_i,
  input  back_status_t status_i,
  input  logic         q_full_i,
  output logic         push_o,
  output op_t          push_op_o
);

  localparam logic [8:0] WL = 9'(PIXEL_WIDTH);
  localparam logic [8:0] HL = 9'(PIXEL_HEIGHT);

  logic [7:0] bm_left_q, bm_top_q, bm_cols_q, bm_rows_q, bm_row_q;
  logic [4:0] bm_byte_q;

  logic       accept;
  logic [8:0] fx_end, fy_end, fx_clip, fy_clip;
  logic [7:0] bm_base;
  logic [8:0] bm_span, bm_colend, bx0, bx_end, bx_clip, by;
  logic       bm_active;
  logic [5:0] per_row, byte_next;
  logic [7:0] inv_rev;
  op_t        op;
  logic       want;

  assign in_stall_o = q_full_i || status_i.clearing;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the request and clip it to the screen
  always_comb begin
    fx_end    = {1'b0, x_i} + {1'b0, width_i};
    fy_end    = {1'b0, y_i} + {1'b0, height_i};
    fx_clip   = (fx_end > WL) ? WL : fx_end;
    fy_clip   = (fy_end > HL) ? HL : fy_end;
    bm_base   = {bm_byte_q, 3'b000};
    bm_span   = {1'b0, bm_base} + 9'd8;
    bm_colend = (bm_span > {1'b0, bm_cols_q}) ? {1'b0, bm_cols_q} : bm_span;
    bx0       = {1'b0, bm_left_q} + {1'b0, bm_base};
    bx_end    = {1'b0, bm_left_q} + bm_colend;
    bx_clip   = (bx_end > WL) ? WL : bx_end;
    by        = {1'b0, bm_top_q} + {1'b0, bm_row_q};
    bm_active = (bm_cols_q != 8'd0) && (bm_row_q < bm_rows_q);
    per_row   = 6'(({1'b0, bm_cols_q} + 9'd7) >> 3);
    byte_next = {1'b0, bm_byte_q} + 6'd1;
    for (int k = 0; k < 8; k++) inv_rev[k] = ~image_byte_i[7-k];

    op            = '0;
    op.is_refresh = 1'b0;
    op.x_first    = x_i;
    op.x_last     = x_i;
    op.y_first    = y_i;
    op.y_last     = y_i;
    op.pattern    = {8{colour_i}};
    want          = 1'b0;
    unique case (command_i)
      CMD_PIXEL: begin
        want = ({1'b0, x_i} < WL) && ({1'b0, y_i} < HL);
      end
      CMD_FILL: begin
        op.x_last = 8'(fx_clip - 9'd1);
        op.y_last = 8'(fy_clip - 9'd1);
        want = ({1'b0, x_i} < fx_clip) && ({1'b0, y_i} < fy_clip);
      end
      CMD_BM_BYTE: begin
        op.x_first = bx0[7:0];
        op.x_last  = 8'(bx_clip - 9'd1);
        op.y_first = by[7:0];
        op.y_last  = by[7:0];
        op.pattern = inv_rev;
        want = bm_active && (bx0 < WL) && (by < HL);
      end
      CMD_REFRESH: begin
        op.is_refresh = 1'b1;
        want = 1'b1;
      end
      default: want = 1'b0;
    endcase
  end

  assign push_o    = accept && want;
  assign push_op_o = op;

  // Hold bitmap origin, size and cursors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bm_left_q <= '0;
      bm_top_q  <= '0;
      bm_cols_q <= '0;
      bm_rows_q <= '0;
      bm_row_q  <= '0;
      bm_byte_q <= '0;
    end else if (accept) begin
      if (command_i == CMD_BM_START) begin
        bm_left_q <= x_i;
        bm_top_q  <= y_i;
        bm_cols_q <= width_i;
        bm_rows_q <= height_i;
        bm_row_q  <= '0;
        bm_byte_q <= '0;
      end else if (command_i == CMD_BM_BYTE && bm_active) begin
        if (byte_next >= per_row) begin
          bm_byte_q <= '0;
          bm_row_q  <= bm_row_q + 8'd1;
        end else begin
          bm_byte_q <= byte_next[4:0];
        end
      end
    end
  end

endmodule

>>> rtl/mfb_back.sv
module mfb_back import mfb_pkg::*; #(
  parameter int PIXEL_WIDTH  = 128,
  parameter int PIXEL_HEIGHT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  op_t          head_op_i,
  input  logic         q_empty_i,
  output logic         pop_o,
  output back_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         is_data_o,
  output logic         frame_end_o
);

  localparam int STORE = PIXEL_WIDTH * PIXEL_HEIGHT / 8;
  localparam int PAGES = PIXEL_HEIGHT / 8;
  localparam int AW    = $clog2(STORE);
  localparam int LW    = 14;
  localparam int PHW   = $clog2(PIXEL_WIDTH + 4);
  localparam int PGW   = $clog2(PAGES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WORK  = 2'd3;

  logic [7:0]     mem [STORE];
  logic [7:0]     rd_q;

  logic [1:0]     state_q, state_d;
  logic [AW-1:0]  clr_q;
  op_t            op_q;
  logic [7:0]     col_q, col_d;
  logic [4:0]     page_q, page_d;
  logic [LW-1:0]  addr_q;
  logic           addr_ok_q;
  logic [PHW-1:0] ph_q;
  logic [PGW-1:0] rpg_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           is_data_q, frame_end_q;

  logic [8:0]     sel_col;
  logic [4:0]     sel_page;
  logic [LW-1:0]  addr;
  logic [2:0]     lo, hi, k;
  logic [7:0]     mask, new_byte;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           emit;
  logic [7:0]     emit_byte;
  logic           emit_data, emit_end;
  logic           ph_cmd;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign ph_cmd = (ph_q < PHW'(3));

  // Store address of the current column or refresh byte
  always_comb begin
    if (op_q.is_refresh) begin
      sel_col  = 9'(ph_q - PHW'(3));
      sel_page = 5'(rpg_q);
    end else begin
      sel_col  = {1'b0, col_q};
      sel_page = page_q;
    end
    addr = LW'(sel_col) + LW'(sel_page) * LW'(PIXEL_WIDTH);
  end

  // Merge the page mask into the byte read back
  always_comb begin
    lo   = (page_q == op_q.y_first[7:3]) ? op_q.y_first[2:0] : 3'd0;
    hi   = (page_q == op_q.y_last[7:3]) ? op_q.y_last[2:0] : 3'd7;
    mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    k    = 3'(col_q - op_q.x_first);
    new_byte = op_q.pattern[k] ? (rd_q | mask) : (rd_q & ~mask);
  end

  // Refresh byte selection
  always_comb begin
    emit      = (state_q == ST_WORK) && op_q.is_refresh && (!out_valid_q || !out_stall_i);
    emit_data = !ph_cmd;
    emit_end  = 1'b0;
    priority if (ph_q == PHW'(0)) begin
      emit_byte = PAGE_ADDR_BASE + 8'(rpg_q);
    end else if (ph_q == PHW'(1)) begin
      emit_byte = COL_LOW_CMD;
    end else if (ph_q == PHW'(2)) begin
      emit_byte = COL_HIGH_CMD;
    end else begin
      emit_byte = addr_ok_q ? rd_q : 8'h00;
      emit_end  = (ph_q == PHW'(PIXEL_WIDTH + 2)) && (rpg_q == PGW'(PAGES - 1));
    end
  end

  // Store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = 8'h00;
    if (state_q == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state_q == ST_WORK && !op_q.is_refresh) begin
      wr_en   = addr_ok_q;
      wr_addr = addr_q[AW-1:0];
      wr_data = new_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_q == ST_READ) rd_q <= mem[addr[AW-1:0]];
  end

  // Sequence clearing, region walk and refresh steps
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    page_d  = page_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(STORE - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_READ;
          col_d   = head_op_i.x_first;
          page_d  = head_op_i.y_first[7:3];
        end
      end
      ST_READ: state_d = ST_WORK;
      ST_WORK: begin
        if (op_q.is_refresh) begin
          if (emit) state_d = ST_IDLE;
        end else if (col_q == op_q.x_last) begin
          if (page_q == op_q.y_last[7:3]) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            page_d  = page_q + 5'd1;
            col_d   = op_q.x_first;
          end
        end else begin
          state_d = ST_READ;
          col_d   = col_q + 8'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      op_q        <= '0;
      col_q       <= '0;
      page_q      <= '0;
      addr_q      <= '0;
      addr_ok_q   <= 1'b0;
      ph_q        <= '0;
      rpg_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      is_data_q   <= 1'b0;
      frame_end_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      page_q  <= page_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (pop_o) op_q <= head_op_i;
      if (state_q == ST_READ) begin
        addr_q    <= addr;
        addr_ok_q <= (addr < LW'(STORE));
      end
      // Drop a taken result, load a new one
      if (emit) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= emit_byte;
        is_data_q   <= emit_data;
        frame_end_q <= emit_end;
        if (ph_q == PHW'(PIXEL_WIDTH + 2)) begin
          ph_q  <= '0;
          rpg_q <= (rpg_q == PGW'(PAGES - 1)) ? '0 : rpg_q + PGW'(1);
        end else begin
          ph_q <= ph_q + PHW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_data_o   = is_data_q;
  assign frame_end_o = frame_end_q;

endmodule

>>> rtl/mono_framebuffer_draw_refresh.sv
// Monochrome page-organised frame store with drawing requests and a refresh
// byte stream. After reset the store (PIXEL_WIDTH*PIXEL_HEIGHT/8 bytes, 1024
// at the defaults) is cleared one byte per cycle; in_stall_o stays high
// meanwhile. A front stage clips each request and queues it (two entries);
// the back stage walks the store with a read-modify-write of one byte at a
// time, a read state then a work state, and takes the next queued op only
// when idle. A pixel request touches one store byte, a bitmap-byte request
// up to eight, and a fill one byte per column per page; a refresh step emits
// one byte and waits while a held result register is stalled.
module mono_framebuffer_draw_refresh import mfb_pkg::*; #(
  parameter int PIXEL_WIDTH  = 128,
  parameter int PIXEL_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] width_i,
  input  logic [7:0] height_i,
  input  logic       colour_i,
  input  logic [7:0] image_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       frame_end_o
);

  back_status_t status;
  logic         push, pop, q_full, q_empty;
  op_t          push_op, head_op;

  mfb_front #(.PIXEL_WIDTH(PIXEL_WIDTH), .PIXEL_HEIGHT(PIXEL_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .command_i, .x_i, .y_i, .width_i, .height_i, .colour_i, .image_byte_i,
    .status_i(status), .q_full_i(q_full), .push_o(push), .push_op_o(push_op)
  );

  mfb_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_op_i(push_op), .full_o(q_full),
    .pop_i(pop), .head_op_o(head_op), .empty_o(q_empty)
  );

  mfb_back #(.PIXEL_WIDTH(PIXEL_WIDTH), .PIXEL_HEIGHT(PIXEL_HEIGHT)) u_back (
    .clk_i, .rst_ni, .head_op_i(head_op), .q_empty_i(q_empty), .pop_o(pop),
    .status_o(status), .out_valid_o, .out_stall_i, .out_byte_o, .is_data_o,
    .frame_end_o
  );

`ifndef NO_ASSERTIONS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> in_stall_o) else $error("request accepted while clearing");
  a_end_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> is_data_o) else $error("frame end on command byte");
  a_cmd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> out_byte_o == COL_LOW_CMD ||
      out_byte_o == COL_HIGH_CMD || out_byte_o[7:4] == PAGE_ADDR_BASE[7:4])
    else $error("bad refresh command byte");
`endif

endmodule

>>> tb/mfb_refresh_checker.sv
module mfb_refresh_checker import mfb_pkg::*; #(
  parameter int PIXEL_WIDTH  = 128,
  parameter int PIXEL_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] command_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] width_i,
  input  logic [7:0] height_i,
  input  logic       colour_i,
  input  logic [7:0] image_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       is_data_i,
  input  logic       frame_end_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreBytes = PIXEL_WIDTH * PIXEL_HEIGHT / 8;
  localparam int PageCount  = PIXEL_HEIGHT / 8;

  typedef struct packed {
    logic [7:0] value;
    logic       data;
    logic       last;
  } stream_byte_t;

  stream_byte_t awaited_bytes[$];
  logic [7:0]   frame_img[StoreBytes];
  logic [7:0]   bm_left, bm_top, bm_cols, bm_rows, bm_row;
  logic [4:0]   bm_col_byte;
  int unsigned  page, phase;

  // Light or clear one pixel; drop it when off-screen
  function automatic void draw_dot(int unsigned px, int unsigned py, bit on);
    int unsigned idx;
    if (px >= PIXEL_WIDTH || py >= PIXEL_HEIGHT) return;
    idx = px + (py / 8) * PIXEL_WIDTH;
    if (on) frame_img[idx][py % 8] = 1'b1;
    else frame_img[idx][py % 8] = 1'b0;
  endfunction

  // Paint one bitmap byte, zero bits light, and advance the cursors
  function automatic void push_bitmap_byte(logic [7:0] bits);
    int unsigned per_row;
    int unsigned col;
    if (bm_cols == 0 || bm_row >= bm_rows) return;
    per_row = (int'(bm_cols) + 7) / 8;
    for (int k = 0; k < 8; k++) begin
      col = int'(bm_col_byte) * 8 + k;
      if (col >= bm_cols) break;
      draw_dot(int'(bm_left) + col, int'(bm_top) + int'(bm_row), bits[7-k] == 1'b0);
    end
    bm_col_byte = bm_col_byte + 5'd1;
    if (bm_col_byte >= per_row || bm_col_byte == 5'd0) begin
      bm_col_byte = 5'd0;
      bm_row = bm_row + 8'd1;
    end
  endfunction

  // Produce the next byte of the page stream
  function automatic stream_byte_t next_stream_byte();
    stream_byte_t sb;
    sb = '0;
    if (phase == 0) sb.value = PAGE_ADDR_BASE + 8'(page);
    else if (phase == 1) sb.value = COL_LOW_CMD;
    else if (phase == 2) sb.value = COL_HIGH_CMD;
    else begin
      sb.value = frame_img[(phase - 3) + page * PIXEL_WIDTH];
      sb.data = 1'b1;
      sb.last = (phase - 2 >= PIXEL_WIDTH) && (page + 1 >= PageCount);
    end
    phase++;
    if (phase >= 3 + PIXEL_WIDTH) begin
      phase = 0;
      page = (page + 1 >= PageCount) ? 0 : page + 1;
    end
    return sb;
  endfunction

  // Compare accepted results, then predict from accepted requests
  always @(posedge clk_i or negedge rst_ni) begin : predict_compare
    stream_byte_t want;
    int unsigned xe, ye;
    if (!rst_ni) begin
      foreach (frame_img[i]) frame_img[i] = '0;
      {bm_left, bm_top, bm_cols, bm_rows, bm_row} = '0;
      bm_col_byte = '0;
      page = 0;
      phase = 0;
      awaited_bytes.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_bytes.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("%t: unexpected stream byte %h data %b end %b", $realtime,
                     out_byte_i, is_data_i, frame_end_i);
        end else begin
          want = awaited_bytes.pop_front();
          if (want != {out_byte_i, is_data_i, frame_end_i}) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("%t: stream byte expected %h/%b/%b got %h/%b/%b", $realtime,
                       want.value, want.data, want.last, out_byte_i, is_data_i,
                       frame_end_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_PIXEL: draw_dot(x_i, y_i, colour_i);
          CMD_FILL: begin
            xe = int'(x_i) + int'(width_i);
            ye = int'(y_i) + int'(height_i);
            if (xe > PIXEL_WIDTH) xe = PIXEL_WIDTH;
            if (ye > PIXEL_HEIGHT) ye = PIXEL_HEIGHT;
            for (int unsigned cx = x_i; cx < xe; cx++)
              for (int unsigned cy = y_i; cy < ye; cy++) draw_dot(cx, cy, colour_i);
          end
          CMD_BM_START: begin
            bm_left = x_i;
            bm_top = y_i;
            bm_cols = width_i;
            bm_rows = height_i;
            bm_row = '0;
            bm_col_byte = '0;
          end
          CMD_BM_BYTE: push_bitmap_byte(image_byte_i);
          CMD_REFRESH: awaited_bytes.push_back(next_stream_byte());
          default: ;
        endcase
      end
      pending_o <= awaited_bytes.size();
    end
  end

endmodule

>>> tb/tb.sv
module tb import mfb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] command_i = '0;
  logic [7:0] x_i = '0, y_i = '0, width_i = '0, height_i = '0, image_byte_i = '0;
  logic       colour_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_data_o, frame_end_o;
  int         fail_count, pending;
  bit         quiet = 1'b0;
  bit         hold_out = 1'b0;
  bit         held = 1'b0;
  bit         drained = 1'b0;
  int         sent = 0;

  always #10 clk_i = ~clk_i;

  mono_framebuffer_draw_refresh dut (.*);

  mfb_refresh_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .x_i, .y_i,
    .width_i, .height_i, .colour_i, .image_byte_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_byte_i(out_byte_o), .is_data_i(is_data_o),
    .frame_end_i(frame_end_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one request; return at its accepting edge or after a random gap
  task automatic send_req(logic [2:0] cmd, logic [7:0] px, logic [7:0] py,
                          logic [7:0] w, logic [7:0] h, logic c, logic [7:0] img);
    command_i <= cmd;
    x_i <= px;
    y_i <= py;
    width_i <= w;
    height_i <= h;
    colour_i <= c;
    image_byte_i <= img;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sent++;
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Send a request with a random filler image byte
  task automatic send_cmd(logic [2:0] cmd, logic [7:0] px, logic [7:0] py,
                          logic [7:0] w, logic [7:0] h, logic c);
    send_req(cmd, px, py, w, h, c, 8'($urandom));
  endtask

  // Stall the result side at random, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 17);
      end
    end
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int roll, cols, rows, nbytes;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bytes without a start, unused commands, extremes and clipping
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h00);
    send_req(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF);
    send_req(3'd6, 0, 0, 0, 0, 0, 0);
    send_req(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 1);
    send_cmd(CMD_PIXEL, 127, 63, 8'hFF, 8'hFF, 1);
    send_cmd(CMD_PIXEL, 128, 0, 0, 0, 1);
    send_cmd(CMD_PIXEL, 0, 64, 0, 0, 1);
    send_cmd(CMD_PIXEL, 255, 255, 0, 0, 1);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 0);
    send_cmd(CMD_FILL, 10, 10, 0, 20, 1);
    send_cmd(CMD_FILL, 10, 10, 20, 0, 1);
    send_cmd(CMD_FILL, 120, 60, 255, 255, 1);
    send_cmd(CMD_FILL, 0, 0, 255, 255, 1);
    send_cmd(CMD_FILL, 3, 5, 7, 9, 0);
    send_cmd(CMD_BM_START, 4, 2, 0, 3, 0);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h00);
    send_cmd(CMD_BM_START, 122, 61, 10, 2, 0);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h5A);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h00);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'hFF);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h3C);
    send_req(CMD_BM_BYTE, 0, 0, 0, 0, 0, 8'h00);
    repeat (3) send_cmd(CMD_REFRESH, 0, 0, 0, 0, 0);

    // Random: refresh-heavy mix with bitmap sequences and small fills
    while (sent < 1400) begin
      quiet = (sent >= 600 && sent < 800);
      if (!held && sent >= 300) begin
        held = 1'b1;
        hold_out = 1'b1;
      end
      if (!drained && sent >= 1000) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      roll = $urandom_range(99);
      if (roll < 65) begin
        send_cmd(CMD_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom));
      end else if (roll < 78) begin
        send_cmd(CMD_PIXEL, 8'($urandom_range(0, 140)), 8'($urandom_range(0, 72)),
                 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (roll < 88) begin
        if ($urandom_range(9) == 0)
          send_cmd(CMD_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
        else
          send_cmd(CMD_FILL, 8'($urandom_range(0, 135)), 8'($urandom_range(0, 70)),
                   8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)), 1'($urandom));
      end else if (roll < 97) begin
        if ($urandom_range(9) == 0) begin
          cols = $urandom_range(0, 255);
          rows = $urandom_range(0, 2);
        end else begin
          cols = $urandom_range(1, 24);
          rows = $urandom_range(0, 10);
        end
        send_cmd(CMD_BM_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'(cols), 8'(rows), 1'($urandom));
        if ($urandom_range(3) != 0) begin
          send_cmd(CMD_BM_START, 8'($urandom_range(0, 130)), 8'($urandom_range(0, 66)),
                   8'(cols), 8'(rows), 1'($urandom));
        end
        nbytes = rows * ((cols + 7) / 8) + $urandom_range(0, 2);
        if (nbytes > 70) nbytes = 70;
        repeat (nbytes)
          send_req(CMD_BM_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom), 8'($urandom));
      end else begin
        send_req(CMD_BM_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom), 8'($urandom));
        send_req(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // Drain the stream and let the back stage settle
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> mono_framebuffer_draw_refresh.f
rtl/mfb_pkg.sv
rtl/mfb_queue.sv
rtl/mfb_front.sv
rtl/mfb_back.sv
rtl/mono_framebuffer_draw_refresh.sv
tb/mfb_refresh_checker.sv
tb/tb.sv
